### rtl/token_router_same_host_top_defines.svh
// Assertion macros for the token router.
// Included by files that carry concurrent checks; expects clk and arst_n in scope.
`ifndef TOKEN_ROUTER_SAME_HOST_TOP_DEFINES_SVH
`define TOKEN_ROUTER_SAME_HOST_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TRSH_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define TRSH_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/trsh_pkg.sv
// Shared types and codes for the token router.
// No dependencies.
package trsh_pkg;

	localparam int SEQ_W      = 64;
	localparam int RESULT_CAP = 64;
	localparam int CFG_IDX_W  = 4;

	localparam logic [1:0] KIND_TOKEN = 2'd0;
	localparam logic [1:0] KIND_ROUTE = 2'd1;
	localparam logic [1:0] KIND_BUILD = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PART   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RECV_CNT   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOST_IDS   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOST_KNOWN = 4'd3;

	typedef struct packed {
		logic [1:0]       kind;
		logic [3:0]       rank;
		logic [SEQ_W-1:0] seq;
	} item_t;

	typedef struct packed {
		logic             valid_res;
		logic [SEQ_W-1:0] out_seq;
		logic [3:0]       dest_rank;
		logic             last;
		logic             tokens_lost;
	} result_t;

endpackage

### rtl/trsh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module trsh_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/token_router_same_host_top.sv
// Token router top: credit RAM, scan sequencer, build sequencer, result register.
// Depends on trsh_pkg, trsh_ram and token_router_same_host_top_defines.svh.
// Token: read the rank's credit (TOK_RD), then update it (TOK_UPD). Route: scan every rank, then pick (RT_PICK).
// Build: one turn check per turn, then a read and a check per rank per turn;
// route and build stall while the result register is full.
// Reset is asynchronous; credits read as zero through per-rank valid bits, no sweep.
`include "token_router_same_host_top_defines.svh"

module token_router_same_host_top
	import trsh_pkg::*;
#(
	parameter int RANKS     = 16,
	parameter int TOKEN_MAX = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SEQ_W-1:0]     cfg_data
);

	localparam int RW = $clog2(RANKS);
	localparam int SW = $clog2(RANKS + 1);
	localparam int CW = $clog2(TOKEN_MAX + 1);
	localparam int NW = $clog2(RESULT_CAP + 1);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_TOK_RD   = 4'd1;
	localparam logic [3:0] ST_TOK_UPD  = 4'd2;
	localparam logic [3:0] ST_RT_SCAN  = 4'd3;
	localparam logic [3:0] ST_RT_PICK  = 4'd4;
	localparam logic [3:0] ST_BLD_TEST = 4'd5;
	localparam logic [3:0] ST_BLD_RD   = 4'd6;
	localparam logic [3:0] ST_BLD_CHK  = 4'd7;
	localparam logic [3:0] ST_BLD_END  = 4'd8;

	function automatic logic [3:0] rank_lsb(input logic [RW-1:0] r);
		logic [6:0] w;
		w = 7'(r);
		return w[3:0];
	endfunction

	// configuration
	logic signed [5:0]  min_part_q;
	logic [4:0]         recv_cnt_q;
	logic [63:0]        host_ids_q;
	logic [15:0]        host_known_q;

	// sequencer and state
	logic [3:0]         state_q;
	logic [SW-1:0]      scan_q;
	logic [SW-1:0]      active_q;
	logic [NW-1:0]      n_q;
	logic               lost_q;
	logic [SEQ_W-1:0]   next_seq_q;
	logic [RANKS-1:0]   cred_vld_q;

	// current item
	logic [RW-1:0]      rank_q;
	logic [SEQ_W-1:0]   seq_q;
	logic               req_known_q;
	logic [3:0]         req_host_q;

	// compare unit state
	logic [RW-1:0]      best_all_q;
	logic [RW-1:0]      best_host_q;
	logic [CW-1:0]      max_all_q;
	logic [CW-1:0]      max_host_q;

	// held build assignment, so the final one can carry last
	logic               pend_vld_q;
	logic [SEQ_W-1:0]   pend_seq_q;
	logic [RW-1:0]      pend_rank_q;

	// read pipeline
	logic               rd_live_s1;
	logic               rd_known_s1;
	logic [RW-1:0]      rd_idx_s1;

	logic               result_valid_q;
	result_t            result_q;

	logic               ram_we;
	logic [RW-1:0]      ram_waddr;
	logic [CW-1:0]      ram_wdata;
	logic [RW-1:0]      ram_raddr;
	logic [CW-1:0]      ram_rdata;
	logic [CW-1:0]      credit;

	logic               out_free;
	logic               result_load;
	result_t            result_d;

	logic [6:0]         r7;
	logic               r_known;
	logic [3:0]         r_host;
	logic               upd_all;
	logic               upd_host;

	logic               use_host;
	logic               found;
	logic [RW-1:0]      pick_idx;
	logic [CW-1:0]      pick_cnt;

	logic signed [7:0]  min_raw;
	logic signed [7:0]  min_need;
	logic signed [7:0]  act_s;
	logic               turn_ok;

	logic               has;
	logic               emit_ok;
	logic               take;
	logic               rank_ok;

	trsh_ram #(
		.WIDTH(CW),
		.DEPTH(RANKS)
	) u_credit_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign item_ready   = (state_q == ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign out_free  = !result_valid_q || result_ready;
	assign credit    = rd_known_s1 ? ram_rdata : '0;
	assign ram_raddr = (state_q == ST_TOK_RD) ? rank_q : scan_q[RW-1:0];
	assign rank_ok   = 7'(item.rank) < 7'(RANKS);

	// compare unit: one credit per cycle against running maxima
	assign r7       = 7'(rd_idx_s1);
	assign r_known  = (r7 < 7'd16) && host_known_q[r7[3:0]];
	assign r_host   = host_ids_q[{r7[3:0], 2'b00} +: 4];
	assign upd_all  = rd_live_s1 && (credit > max_all_q);
	assign upd_host = rd_live_s1 && req_known_q && r_known && (r_host == req_host_q)
		&& (credit > max_host_q);

	assign use_host = (max_host_q != '0);
	assign found    = (max_all_q != '0);
	assign pick_idx = use_host ? best_host_q : best_all_q;
	assign pick_cnt = use_host ? max_host_q : max_all_q;

	// minimum number of ranks with credits for another build turn
	always_comb begin
		if (min_part_q > 6'sd0) begin
			min_raw = $signed({{2{min_part_q[5]}}, min_part_q});
		end else begin
			min_raw = $signed({3'b000, recv_cnt_q}) + $signed({{2{min_part_q[5]}}, min_part_q});
		end
		min_need = (min_raw < 8'sd1) ? 8'sd1 : min_raw;
		act_s    = $signed(8'(active_q));
	end

	assign turn_ok = (active_q != '0) && (act_s >= min_need)
		&& ((8'(n_q) + 8'(active_q)) <= 8'(RESULT_CAP));

	assign has     = (credit != '0);
	assign emit_ok = !pend_vld_q || out_free;
	assign take    = has && emit_ok;

	// credit writes and result loads
	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = rank_q;
		ram_wdata   = credit + CW'(1);
		result_load = 1'b0;
		result_d    = '0;
		result_d.tokens_lost = lost_q;
		unique case (state_q)
			ST_TOK_UPD: begin
				ram_we = (credit < CW'(TOKEN_MAX));
			end
			ST_RT_PICK: begin
				if (out_free) begin
					result_load        = 1'b1;
					ram_we             = found;
					ram_waddr          = pick_idx;
					ram_wdata          = pick_cnt - CW'(1);
					result_d.valid_res = found;
					result_d.out_seq   = found ? seq_q : '0;
					result_d.dest_rank = found ? rank_lsb(pick_idx) : 4'd0;
					result_d.last      = 1'b1;
				end
			end
			ST_BLD_CHK: begin
				if (take) begin
					ram_we             = 1'b1;
					ram_waddr          = scan_q[RW-1:0];
					ram_wdata          = credit - CW'(1);
					result_load        = pend_vld_q;
					result_d.valid_res = 1'b1;
					result_d.out_seq   = pend_seq_q;
					result_d.dest_rank = rank_lsb(pend_rank_q);
				end
			end
			ST_BLD_END: begin
				if (out_free) begin
					result_load        = 1'b1;
					result_d.valid_res = pend_vld_q;
					result_d.out_seq   = pend_vld_q ? pend_seq_q : '0;
					result_d.dest_rank = pend_vld_q ? rank_lsb(pend_rank_q) : 4'd0;
					result_d.last      = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_part_q   <= '0;
			recv_cnt_q   <= '0;
			host_ids_q   <= '0;
			host_known_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MIN_PART:   min_part_q   <= $signed(cfg_data[5:0]);
				CFG_RECV_CNT:   recv_cnt_q   <= cfg_data[4:0];
				CFG_HOST_IDS:   host_ids_q   <= cfg_data;
				CFG_HOST_KNOWN: host_known_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// read pipeline and credit valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_live_s1  <= 1'b0;
			rd_known_s1 <= 1'b0;
			cred_vld_q  <= '0;
		end else begin
			rd_live_s1  <= (state_q == ST_RT_SCAN) && (scan_q != SW'(RANKS));
			rd_known_s1 <= cred_vld_q[ram_raddr];
			if (ram_we) begin
				cred_vld_q[ram_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q[RW-1:0];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (result_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			result_q <= result_d;
		end
	end

	// payload of the current transaction and compare unit
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			rank_q      <= RW'(item.rank);
			seq_q       <= item.seq;
			req_known_q <= host_known_q[item.rank];
			req_host_q  <= host_ids_q[{item.rank, 2'b00} +: 4];
			max_all_q   <= '0;
			max_host_q  <= '0;
		end else begin
			if (upd_all) begin
				max_all_q  <= credit;
				best_all_q <= rd_idx_s1;
			end
			if (upd_host) begin
				max_host_q  <= credit;
				best_host_q <= rd_idx_s1;
			end
		end
		if (state_q == ST_BLD_CHK && take) begin
			pend_seq_q  <= next_seq_q;
			pend_rank_q <= scan_q[RW-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_q     <= '0;
			active_q   <= '0;
			n_q        <= '0;
			lost_q     <= 1'b0;
			next_seq_q <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						case (item.kind)
							KIND_TOKEN: begin
								if (rank_ok) begin
									state_q <= ST_TOK_RD;
								end
							end
							KIND_ROUTE: begin
								scan_q  <= '0;
								state_q <= ST_RT_SCAN;
							end
							KIND_BUILD: begin
								n_q        <= '0;
								pend_vld_q <= 1'b0;
								state_q    <= ST_BLD_TEST;
							end
							default: begin
							end
						endcase
					end
				end
				ST_TOK_RD: begin
					state_q <= ST_TOK_UPD;
				end
				ST_TOK_UPD: begin
					if (credit >= CW'(TOKEN_MAX)) begin
						lost_q <= 1'b1;
					end else if (credit == '0) begin
						active_q <= active_q + SW'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_RT_SCAN: begin
					// last read data is compared in the cycle that leaves this state
					if (scan_q == SW'(RANKS)) begin
						state_q <= ST_RT_PICK;
					end else begin
						scan_q <= scan_q + SW'(1);
					end
				end
				ST_RT_PICK: begin
					if (out_free) begin
						if (found && pick_cnt == CW'(1)) begin
							active_q <= active_q - SW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_BLD_TEST: begin
					scan_q  <= '0;
					state_q <= turn_ok ? ST_BLD_RD : ST_BLD_END;
				end
				ST_BLD_RD: begin
					state_q <= ST_BLD_CHK;
				end
				ST_BLD_CHK: begin
					if (take) begin
						pend_vld_q <= 1'b1;
						next_seq_q <= next_seq_q + 64'd1;
						n_q        <= n_q + NW'(1);
						if (credit == CW'(1)) begin
							active_q <= active_q - SW'(1);
						end
					end
					if (!has || emit_ok) begin
						if (scan_q == SW'(RANKS - 1)) begin
							state_q <= ST_BLD_TEST;
						end else begin
							scan_q  <= scan_q + SW'(1);
							state_q <= ST_BLD_RD;
						end
					end
				end
				ST_BLD_END: begin
					if (out_free) begin
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`TRSH_CHECK_NOW(a_active_bound, 1'b1, active_q <= SW'(RANKS), "active rank count exceeds RANKS")
	`TRSH_CHECK_NOW(a_build_cap, state_q != ST_IDLE, n_q <= NW'(RESULT_CAP), "build result count past cap")
	`TRSH_CHECK_NEXT(a_lost_sticky, lost_q, lost_q, "lost flag cleared outside reset")
	`TRSH_CHECK_NEXT(a_pick_emits, (state_q == ST_RT_PICK) && out_free, result_valid_q && (state_q == ST_IDLE), "route pick did not emit a result")

endmodule
